// ===== src/hsl_pkg.sv =====
// Shared widths, constants, segment codes and control types of the HSL to RGB converter.
`default_nettype none
package hsl_pkg;

	localparam int HUE_W  = 11;             // hue field width
	localparam int UNIT_W = 9;              // Q1.8 field width
	localparam int LVL_W  = UNIT_W + 1;     // upper level and span width
	localparam int FRAC_W = UNIT_W;         // ramp position, 0..256
	localparam int PROD_W = LVL_W + FRAC_W; // span times ramp position
	localparam int SUM_W  = HUE_W + 1;      // hue plus offset before wrap

	localparam logic [UNIT_W-1:0] ONE_Q     = UNIT_W'(256);
	localparam logic [UNIT_W-1:0] HALF_Q    = UNIT_W'(128);
	localparam logic [HUE_W-1:0]  HUE_TURN  = HUE_W'(1536);
	localparam logic [HUE_W-1:0]  HUE_SIXTH = HUE_W'(256);
	localparam logic [HUE_W-1:0]  HUE_THIRD = HUE_W'(512);
	localparam logic [HUE_W-1:0]  HUE_ZERO  = HUE_W'(0);
	localparam logic [HUE_W-1:0]  HUE_2THRD = HUE_W'(1024);

	// Piecewise segment of a channel's hue
	localparam logic [1:0] SEG_RISE = 2'd0;
	localparam logic [1:0] SEG_HIGH = 2'd1;
	localparam logic [1:0] SEG_FALL = 2'd2;
	localparam logic [1:0] SEG_LOW  = 2'd3;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage
`default_nettype wire

// ===== src/hsl_if.sv =====
// Valid/ready channel interfaces for HSL pixels in and RGB pixels out.
`default_nettype none
interface hsl_in_if;
	logic                       valid;
	logic                       ready;
	logic [hsl_pkg::HUE_W-1:0]  hue;
	logic [hsl_pkg::UNIT_W-1:0] saturation;
	logic [hsl_pkg::UNIT_W-1:0] lightness;

	modport source (output valid, output hue, output saturation, output lightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input lightness,
		output ready);
endinterface

interface hsl_out_if;
	logic                       valid;
	logic                       ready;
	logic [hsl_pkg::UNIT_W-1:0] red;
	logic [hsl_pkg::UNIT_W-1:0] green;
	logic [hsl_pkg::UNIT_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== src/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB converter: four-stage pipeline with valid/ready flow control.
//
// Usage:
//   pix carries one HSL item per handshake: hue in 1/1536 of a turn (values of
//   1536 and up wrap), saturation and lightness in Q1.8 (above 256 saturate).
//   rgb carries one item back per input item: red, green, blue in Q1.8,
//   clamped to 0..256, in the order the inputs arrived.
// Stages: an item is registered in s1, s2, s3 and s4 in turn, and rgb.valid is
//   the valid bit of s4.
//   s1 normalizes inputs and forms lightness*saturation,
//   s2 forms upper/lower levels and each channel's hue segment,
//   s3 multiplies level span by ramp position (one multiplier per channel),
//   s4 rounds, adds, clamps into the output register.
// Throughput: one item per clock while rgb.ready stays high.
// Stall: each stage has its own valid bit and loads when it is empty or the
//   stage after it advances, so bubbles close up and pix.ready stays high
//   until all four stages hold items. No item is lost or repeated.
// Reset: arst_n clears all valid bits; the data registers are not reset.
`default_nettype none
module hsl_to_rgb_converter (
	input  wire logic clk,
	input  wire logic arst_n,
	hsl_in_if.sink    pix,
	hsl_out_if.source rgb
);
	hsl_pkg::pipe_en_t en;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	logic [hsl_pkg::HUE_W-1:0]  hue_s1;
	logic [hsl_pkg::LVL_W-1:0]  hi_s2;
	logic [hsl_pkg::UNIT_W-1:0] lo_s2;
	logic [hsl_pkg::LVL_W-1:0]  span_s2;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en.s4 = !valid_s4 || rgb.ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign pix.ready = en.s1;
	assign rgb.valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= pix.valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	hsl_levels u_levels (
		.clk        (clk),
		.en         (en),
		.hue        (pix.hue),
		.saturation (pix.saturation),
		.lightness  (pix.lightness),
		.hue_s1     (hue_s1),
		.hi_s2      (hi_s2),
		.lo_s2      (lo_s2),
		.span_s2    (span_s2)
	);

	// Red leads by a third of a turn, blue by two thirds
	hsl_channel u_red (
		.clk        (clk),
		.en         (en),
		.hue_offset (hsl_pkg::HUE_THIRD),
		.hue_s1     (hue_s1),
		.hi_s2      (hi_s2),
		.lo_s2      (lo_s2),
		.span_s2    (span_s2),
		.level_s4   (rgb.red)
	);

	hsl_channel u_green (
		.clk        (clk),
		.en         (en),
		.hue_offset (hsl_pkg::HUE_ZERO),
		.hue_s1     (hue_s1),
		.hi_s2      (hi_s2),
		.lo_s2      (lo_s2),
		.span_s2    (span_s2),
		.level_s4   (rgb.green)
	);

	hsl_channel u_blue (
		.clk        (clk),
		.en         (en),
		.hue_offset (hsl_pkg::HUE_2THRD),
		.hue_s1     (hue_s1),
		.hi_s2      (hi_s2),
		.lo_s2      (lo_s2),
		.span_s2    (span_s2),
		.level_s4   (rgb.blue)
	);
endmodule
`default_nettype wire

// ===== src/hsl_levels.sv =====
// Stages 1 and 2: input normalization, lightness-saturation product, upper and lower levels.
`default_nettype none
module hsl_levels (
	input  wire logic                       clk,
	input  wire hsl_pkg::pipe_en_t          en,
	input  wire logic [hsl_pkg::HUE_W-1:0]  hue,
	input  wire logic [hsl_pkg::UNIT_W-1:0] saturation,
	input  wire logic [hsl_pkg::UNIT_W-1:0] lightness,
	output logic      [hsl_pkg::HUE_W-1:0]  hue_s1,
	output logic      [hsl_pkg::LVL_W-1:0]  hi_s2,
	output logic      [hsl_pkg::UNIT_W-1:0] lo_s2,
	output logic      [hsl_pkg::LVL_W-1:0]  span_s2
);
	localparam int MUL_W = 2 * hsl_pkg::UNIT_W;

	logic [hsl_pkg::HUE_W-1:0]  hue_n;
	logic [hsl_pkg::UNIT_W-1:0] sat_n;
	logic [hsl_pkg::UNIT_W-1:0] lit_n;
	logic [hsl_pkg::UNIT_W-1:0] sat_s1;
	logic [hsl_pkg::UNIT_W-1:0] lit_s1;
	logic [MUL_W-1:0]           prod_s1;
	logic [MUL_W-1:0]           prod_rnd;
	logic [hsl_pkg::UNIT_W-1:0] ls;
	logic [hsl_pkg::UNIT_W-1:0] dev;

	// Wrap hue into one turn, saturate the unit values
	always_comb begin
		hue_n = (hue >= hsl_pkg::HUE_TURN) ? hue - hsl_pkg::HUE_TURN : hue;
		sat_n = (saturation > hsl_pkg::ONE_Q) ? hsl_pkg::ONE_Q : saturation;
		lit_n = (lightness > hsl_pkg::ONE_Q) ? hsl_pkg::ONE_Q : lightness;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			hue_s1  <= hue_n;
			sat_s1  <= sat_n;
			lit_s1  <= lit_n;
			prod_s1 <= MUL_W'(lit_n) * MUL_W'(sat_n);
		end
	end

	// Distance of the levels from lightness; zero saturation gives zero distance
	always_comb begin
		prod_rnd = prod_s1 + MUL_W'(128);
		ls       = prod_rnd[hsl_pkg::UNIT_W+7:8];
		dev      = (lit_s1 < hsl_pkg::HALF_Q) ? ls : sat_s1 - ls;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hi_s2   <= hsl_pkg::LVL_W'(lit_s1) + hsl_pkg::LVL_W'(dev);
			lo_s2   <= lit_s1 - dev;
			span_s2 <= {dev, 1'b0};
		end
	end
endmodule
`default_nettype wire

// ===== src/hsl_channel.sv =====
// Stages 2 to 4 of one color channel: hue segment, ramp product, rounding and clamp.
`default_nettype none
module hsl_channel (
	input  wire logic                       clk,
	input  wire hsl_pkg::pipe_en_t          en,
	input  wire logic [hsl_pkg::HUE_W-1:0]  hue_offset,
	input  wire logic [hsl_pkg::HUE_W-1:0]  hue_s1,
	input  wire logic [hsl_pkg::LVL_W-1:0]  hi_s2,
	input  wire logic [hsl_pkg::UNIT_W-1:0] lo_s2,
	input  wire logic [hsl_pkg::LVL_W-1:0]  span_s2,
	output logic      [hsl_pkg::UNIT_W-1:0] level_s4
);
	localparam int RND_W = hsl_pkg::PROD_W - 8;
	localparam int VAL_W = RND_W + 1;

	logic [hsl_pkg::SUM_W-1:0]  hue_sum;
	logic [hsl_pkg::HUE_W-1:0]  t;
	logic [hsl_pkg::HUE_W-1:0]  fall_pos;
	logic [1:0]                 seg;
	logic [hsl_pkg::FRAC_W-1:0] frac;
	logic [1:0]                 seg_s2;
	logic [hsl_pkg::FRAC_W-1:0] frac_s2;
	logic [1:0]                 seg_s3;
	logic [hsl_pkg::PROD_W-1:0] prod_s3;
	logic [hsl_pkg::LVL_W-1:0]  hi_s3;
	logic [hsl_pkg::UNIT_W-1:0] lo_s3;
	logic [hsl_pkg::PROD_W-1:0] prod_rnd;
	logic [VAL_W-1:0]           val;

	// Rotate hue for this channel and find its segment
	always_comb begin
		hue_sum  = hsl_pkg::SUM_W'(hue_s1) + hsl_pkg::SUM_W'(hue_offset);
		t        = (hue_sum >= hsl_pkg::SUM_W'(hsl_pkg::HUE_TURN)) ?
			hsl_pkg::HUE_W'(hue_sum - hsl_pkg::SUM_W'(hsl_pkg::HUE_TURN)) :
			hsl_pkg::HUE_W'(hue_sum);
		fall_pos = hsl_pkg::HUE_W'(4 * 256) - t;
		if (t < hsl_pkg::HUE_SIXTH) begin
			seg  = hsl_pkg::SEG_RISE;
			frac = {1'b0, t[7:0]};
		end else if (t < hsl_pkg::HUE_W'(3 * 256)) begin
			seg  = hsl_pkg::SEG_HIGH;
			frac = '0;
		end else if (t < hsl_pkg::HUE_W'(4 * 256)) begin
			seg  = hsl_pkg::SEG_FALL;
			frac = fall_pos[hsl_pkg::FRAC_W-1:0];
		end else begin
			seg  = hsl_pkg::SEG_LOW;
			frac = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2  <= seg;
			frac_s2 <= frac;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			seg_s3  <= seg_s2;
			prod_s3 <= hsl_pkg::PROD_W'(span_s2) * hsl_pkg::PROD_W'(frac_s2);
			hi_s3   <= hi_s2;
			lo_s3   <= lo_s2;
		end
	end

	// Round the ramp, add the lower level, pick by segment
	always_comb begin
		prod_rnd = prod_s3 + hsl_pkg::PROD_W'(128);
		case (seg_s3) inside
			hsl_pkg::SEG_RISE, hsl_pkg::SEG_FALL: begin
				val = VAL_W'(lo_s3) + VAL_W'(prod_rnd[hsl_pkg::PROD_W-1:8]);
			end
			hsl_pkg::SEG_HIGH: val = VAL_W'(hi_s3);
			default:           val = VAL_W'(lo_s3);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			level_s4 <= (val > VAL_W'(hsl_pkg::ONE_Q)) ? hsl_pkg::ONE_Q :
				hsl_pkg::UNIT_W'(val);
		end
	end
endmodule
`default_nettype wire
